// File: src/bitset_set_engine_defines.svh
// ----------------------------------------------------------------------------
// Bit set engine assertion macros
// Shared property shorthands for the checker.
// ----------------------------------------------------------------------------
`ifndef BITSET_SET_ENGINE_DEFINES_SVH
`define BITSET_SET_ENGINE_DEFINES_SVH

// same-cycle implication
`define BSE_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bitset_set_engine: check failed");

// next-cycle implication
`define BSE_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bitset_set_engine: check failed");

`endif

// File: src/bse_pkg.sv
// ----------------------------------------------------------------------------
// Bit set engine package
// Commands, status codes, sequencer states and helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package bse_pkg;

	localparam int NUM_SETS_DEF      = 8;
	localparam int WORDS_PER_SET_DEF = 64;

	localparam int IN_DATA_W  = 104;
	localparam int IN_USER_W  = 3;
	localparam int OUT_DATA_W = 80;
	localparam int OUT_USER_W = 2;

	typedef enum logic [2:0] {
		CMD_EXPAND     = 3'd0,
		CMD_WRITE      = 3'd1,
		CMD_READ       = 3'd2,
		CMD_UNION      = 3'd3,
		CMD_INTERSECT  = 3'd4,
		CMD_COMPLEMENT = 3'd5,
		CMD_EQUAL      = 3'd6,
		CMD_FIND       = 3'd7
	} cmd_t;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_CAP   = 2'd1;
	localparam logic [1:0] STATUS_RANGE = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LA,
		ST_LB,
		ST_EXEC,
		ST_FILL,
		ST_RD,
		ST_WR,
		ST_OUT
	} state_t;

	// index of lowest set bit, halving search
	function automatic logic [5:0] lowest_bit(input logic [63:0] w);
		logic [63:0] v;
		logic [5:0]  p;
		v = w;
		p = '0;
		for (int k = 5; k >= 0; k--) begin
			if ((v & ((64'd1 << (1 << k)) - 64'd1)) == 64'd0) begin
				p[k] = 1'b1;
				v    = v >> (1 << k);
			end
		end
		return p;
	endfunction

endpackage
`default_nettype wire

// File: src/bitset_set_engine.sv
// ----------------------------------------------------------------------------
// Bit set engine
// Bank of word-organized bit sets with word access and set operations.
// ----------------------------------------------------------------------------
// One item in, one item out. Each set is a run of 64-bit words held in a single
// synchronous word memory (one write port, two read ports, registered read
// data); set lengths live in a small register file cleared by reset. The
// memory itself is not cleared: expand and union zero-fill words before they
// come into use. The block works on one item at a time: setup (length fetch
// in LA and LB, dispatch in EXEC), then a FILL state for each zero-filled word
// and, for each word visited, a RD state (memory read) then a WR state
// (modify/write back), then an OUT state that hands the result to the output
// register once it is free. An earlier result may wait in the output register
// while the next item is taken in.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bitset_set_engine #(
	parameter int NUM_SETS      = bse_pkg::NUM_SETS_DEF,
	parameter int WORDS_PER_SET = bse_pkg::WORDS_PER_SET_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_axis_tvalid,
	output logic                             s_axis_tready,
	// set_a, set_b, size_bits, word_index, word_data, previous, 2 pad bits
	input  wire  [bse_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// cmd
	input  wire  [bse_pkg::IN_USER_W-1:0]    s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  wire                              m_axis_tready,
	// read_data, sets_equal, found, position, 1 pad bit
	output logic [bse_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	// status
	output logic [bse_pkg::OUT_USER_W-1:0]   m_axis_tuser
);
	import bse_pkg::*;

	localparam int LW  = $clog2(WORDS_PER_SET + 1);
	localparam int CW  = (LW > 8) ? LW : 8;
	localparam int NSW = $clog2(NUM_SETS);
	localparam int MAW = $clog2(NUM_SETS * WORDS_PER_SET);
	localparam int MD  = NUM_SETS * WORDS_PER_SET;

	state_t state_q, state_d;

	// captured item
	cmd_t        cmd_q;
	logic [2:0]  a_q, b_q;
	logic [12:0] size_q, prev_q;
	logic [5:0]  widx_q;
	logic [63:0] data_q;

	logic [LW-1:0] la_q, lb_q;
	logic [CW-1:0] i_q, n_q;
	logic [5:0]    bit_q;
	logic          first_q;

	// working result
	logic [1:0]  status_q;
	logic [63:0] rdata_q;
	logic        eq_q, fnd_q;
	logic [12:0] pos_q;

	// output register
	logic        out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic [1:0]  out_user_q;

	logic [LW-1:0] len_q [NUM_SETS];
	logic [63:0]   mem [MD];
	logic [63:0]   rd_a_q, rd_b_q;

	logic            mem_we;
	logic [MAW-1:0]  mem_waddr, rd_addr_a, rd_addr_b;
	logic [63:0]     mem_wdata;

	logic            bad_set, uses_b;
	logic [7:0]      exp_words;
	logic [13:0]     start;
	logic [CW-1:0]   la_c, lb_c, i_nx;
	logic            a_ok, b_ok;
	logic [63:0]     wa, wb, fw;
	logic            out_load;

	function automatic logic [MAW-1:0] addr_of(input logic [2:0] s, input logic [CW-1:0] idx);
		return MAW'(MAW'(s) * MAW'(WORDS_PER_SET)) + MAW'(idx);
	endfunction

	assign la_c      = CW'(la_q);
	assign lb_c      = CW'(lb_q);
	assign i_nx      = i_q + CW'(1);
	assign a_ok      = i_q < la_c;
	assign b_ok      = i_q < lb_c;
	assign uses_b    = (cmd_q == CMD_UNION) || (cmd_q == CMD_INTERSECT) || (cmd_q == CMD_EQUAL);
	assign bad_set   = (7'(a_q) >= 7'(NUM_SETS)) || (uses_b && (7'(b_q) >= 7'(NUM_SETS)));
	assign exp_words = {1'b0, size_q[12:6]} + {7'd0, |size_q[5:0]};
	assign start     = {prev_q[12], prev_q} + 14'd1;
	assign wa        = a_ok ? rd_a_q : 64'd0;
	assign wb        = b_ok ? rd_b_q : 64'd0;
	assign fw        = first_q ? (rd_a_q >> bit_q) : rd_a_q;
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

	// word memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_a_q <= mem[rd_addr_a];
		rd_b_q <= mem[rd_addr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer: next state and memory controls
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = addr_of(a_q, i_q);
		mem_wdata = 64'd0;
		rd_addr_a = addr_of(a_q, i_q);
		rd_addr_b = addr_of(b_q, i_q);
		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) state_d = ST_LA;
			end
			ST_LA: state_d = ST_LB;
			ST_LB: state_d = ST_EXEC;
			ST_EXEC: begin
				state_d = ST_OUT;
				if (!bad_set) begin
					case (cmd_q)
						CMD_EXPAND: begin
							if (CW'(exp_words) <= CW'(WORDS_PER_SET) && CW'(exp_words) > la_c)
								state_d = ST_FILL;
						end
						CMD_WRITE: begin
							if (CW'(widx_q) < la_c) begin
								mem_we    = 1'b1;
								mem_waddr = addr_of(a_q, CW'(widx_q));
								mem_wdata = data_q;
							end
						end
						CMD_READ: begin
							if (CW'(widx_q) < la_c) state_d = ST_RD;
						end
						CMD_UNION: begin
							if (la_q < lb_q) state_d = ST_FILL;
							else if (lb_q != '0) state_d = ST_RD;
						end
						CMD_INTERSECT, CMD_COMPLEMENT: begin
							if (la_q != '0) state_d = ST_RD;
						end
						CMD_EQUAL: begin
							if (la_q != '0 || lb_q != '0) state_d = ST_RD;
						end
						CMD_FIND: begin
							if (!(prev_q[12] && prev_q != 13'h1FFF) && CW'(start[13:6]) < la_c)
								state_d = ST_RD;
						end
						default: state_d = ST_OUT;
					endcase
				end
			end
			ST_FILL: begin
				mem_we = 1'b1;
				if (i_nx == n_q) begin
					state_d = (cmd_q == CMD_UNION) ? ST_RD : ST_OUT;
				end
			end
			ST_RD: state_d = ST_WR;
			ST_WR: begin
				state_d = (i_nx == n_q) ? ST_OUT : ST_RD;
				case (cmd_q)
					CMD_UNION: begin
						mem_we    = 1'b1;
						mem_wdata = rd_a_q | rd_b_q;
					end
					CMD_INTERSECT: begin
						mem_we    = 1'b1;
						mem_wdata = b_ok ? (rd_a_q & rd_b_q) : 64'd0;
					end
					CMD_COMPLEMENT: begin
						mem_we    = 1'b1;
						mem_wdata = ~rd_a_q;
					end
					CMD_EQUAL: begin
						if (wa != wb) state_d = ST_OUT;
					end
					CMD_FIND: begin
						if (fw != 64'd0) state_d = ST_OUT;
					end
					default: state_d = ST_OUT;
				endcase
			end
			ST_OUT: begin
				if (out_load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cmd_q    <= cmd_t'(s_axis_tuser[2:0]);
				a_q      <= s_axis_tdata[2:0];
				b_q      <= s_axis_tdata[5:3];
				size_q   <= s_axis_tdata[18:6];
				widx_q   <= s_axis_tdata[24:19];
				data_q   <= s_axis_tdata[88:25];
				prev_q   <= s_axis_tdata[101:89];
				status_q <= STATUS_OK;
				rdata_q  <= 64'd0;
				eq_q     <= 1'b0;
				fnd_q    <= 1'b0;
				pos_q    <= 13'd0;
			end
			ST_LA: la_q <= len_q[NSW'(a_q)];
			ST_LB: lb_q <= len_q[NSW'(b_q)];
			ST_EXEC: begin
				// first word of a scan is shifted down to the start bit
				first_q <= !bad_set && (cmd_q == CMD_FIND);
				if (bad_set) begin
					status_q <= STATUS_CAP;
				end else begin
					case (cmd_q)
						CMD_EXPAND: begin
							if (CW'(exp_words) > CW'(WORDS_PER_SET)) status_q <= STATUS_CAP;
							i_q <= la_c;
							n_q <= CW'(exp_words);
						end
						CMD_WRITE: begin
							if (CW'(widx_q) >= la_c) status_q <= STATUS_RANGE;
						end
						CMD_READ: begin
							if (CW'(widx_q) >= la_c) status_q <= STATUS_RANGE;
							i_q <= CW'(widx_q);
							n_q <= CW'(widx_q) + CW'(1);
						end
						CMD_UNION: begin
							i_q <= (la_q < lb_q) ? la_c : CW'(0);
							n_q <= lb_c;
						end
						CMD_EQUAL: begin
							eq_q <= 1'b1;
							i_q  <= CW'(0);
							n_q  <= (la_q > lb_q) ? la_c : lb_c;
						end
						CMD_FIND: begin
							pos_q   <= prev_q;
							i_q     <= CW'(start[13:6]);
							n_q     <= la_c;
							bit_q   <= start[5:0];
						end
						default: begin
							i_q <= CW'(0);
							n_q <= la_c;
						end
					endcase
				end
			end
			ST_FILL: begin
				if (i_nx == n_q) begin
					i_q <= CW'(0);
				end else begin
					i_q <= i_nx;
				end
			end
			ST_WR: begin
				i_q     <= i_nx;
				first_q <= 1'b0;
				case (cmd_q)
					CMD_READ: rdata_q <= rd_a_q;
					CMD_EQUAL: begin
						if (wa != wb) eq_q <= 1'b0;
					end
					CMD_FIND: begin
						if (fw != 64'd0) begin
							fnd_q <= 1'b1;
							pos_q <= {i_q[6:0], 6'd0} + {7'd0, (first_q ? bit_q : 6'd0)}
								+ {7'd0, lowest_bit(fw)};
						end
					end
					default: rdata_q <= rdata_q;
				endcase
			end
			default: rdata_q <= rdata_q;
		endcase
	end

	// length file, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_SETS; k++) len_q[k] <= '0;
		end else if (state_q == ST_FILL && i_nx == n_q) begin
			len_q[NSW'(a_q)] <= n_q[LW-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {1'b0, pos_q, fnd_q, eq_q, rdata_q};
			out_user_q <= status_q;
		end
	end

endmodule
`default_nettype wire

// File: src/bse_checker.sv
// ----------------------------------------------------------------------------
// Bit set engine checker
// Port-level checks on results, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "bitset_set_engine_defines.svh"
module bse_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        m_axis_tvalid,
	input wire        m_axis_tready,
	input wire [79:0] m_axis_tdata,
	input wire [1:0]  m_axis_tuser
);
	import bse_pkg::*;

	// a stalled result stays offered
	`BSE_ASSERT_NXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	// status is one of the three codes
	`BSE_ASSERT_IMP(a_status, m_axis_tvalid, m_axis_tuser != 2'd3)
	// a hit only comes with good status
	`BSE_ASSERT_IMP(a_found_ok, m_axis_tvalid && m_axis_tdata[65], m_axis_tuser == STATUS_OK)
	// read data and equality never both set
	`BSE_ASSERT_IMP(a_excl, m_axis_tvalid && m_axis_tdata[63:0] != 64'd0, !m_axis_tdata[64])

endmodule

bind bitset_set_engine bse_checker u_bse_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
